>>> hw/rtl/crcdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_pkg - shared types and constants of the CRC-checked frame deframer
// Status codes, reset values and the descriptor that carries a finished
// frame from the front end to the result generator.
// ----------------------------------------------------------------------------
package crcdf_pkg;

    // result status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;

    localparam logic [7:0] CRC_POLY_RST    = 8'hD5;
    localparam int         MAX_PAYLOAD_DEF = 60;
    localparam int         IDX_W           = 6;

    // one finished frame (or one status-only event)
    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       sync;
        logic [7:0]       length;
        logic [7:0]       ftype;
        logic [IDX_W-1:0] plen;
        logic             bank;
    } t_desc;

    // payload bank handed back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

>>> hw/rtl/crcdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data that holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module crcdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 120,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/crcdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_front - frame capture and CRC check
// Tracks the byte position in the frame, checks the length, stores payload
// bytes into the current bank, runs the CRC-8 and queues one descriptor per
// finished frame or error.
// ----------------------------------------------------------------------------
module crcdf_front #(
    parameter int MAX_PAYLOAD = crcdf_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(2 * MAX_PAYLOAD)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  logic [7:0]          i_poly,
    input  logic                i_q_full,
    output logic                o_push,
    output crcdf_pkg::t_desc    o_desc,
    input  crcdf_pkg::t_release i_release,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output logic [7:0]          o_wdata
);
    import crcdf_pkg::*;

    localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 2);

    // one byte through the MSB-first CRC-8, eight shift steps
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    logic       r_cap,   n_cap;
    logic [6:0] r_pos,   n_pos;
    logic [7:0] r_sync,  n_sync;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_type,  n_type;
    logic [7:0] r_crc,   n_crc;
    logic [1:0] r_busy,  n_busy;
    logic       r_wbank, n_wbank;

    logic             acc;
    logic             set_busy;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] plen;

    // a bank still being read out blocks capture into it
    assign o_ready = !i_q_full && !r_busy[r_wbank];
    assign acc     = i_valid && o_ready;
    assign widx    = IDX_W'(r_pos - 7'd3);
    assign plen    = IDX_W'(r_len - 8'd2);

    assign o_wdata = i_byte;
    assign o_waddr = AW'(widx) + (r_wbank ? AW'(MAX_PAYLOAD) : AW'(0));

    // byte classification
    always_comb begin
        n_cap    = r_cap;
        n_pos    = r_pos;
        n_sync   = r_sync;
        n_len    = r_len;
        n_type   = r_type;
        n_crc    = r_crc;
        o_push   = 1'b0;
        o_we     = 1'b0;
        set_busy = 1'b0;
        o_desc   = '{status: ST_GOOD, sync: r_sync, length: r_len, ftype: r_type,
                     plen: plen, bank: r_wbank};
        if (acc) begin
            if (i_start) begin
                n_sync = i_byte;
                n_len  = 8'd0;
                n_type = 8'd0;
                n_crc  = 8'd0;
                n_pos  = 7'd1;
                n_cap  = 1'b1;
            end else if (r_cap) begin
                if (r_pos == 7'd1) begin
                    n_len = i_byte;
                    if (i_byte < 8'd2 || {1'b0, i_byte} > LEN_MAX) begin
                        n_cap         = 1'b0;
                        n_pos         = 7'd0;
                        o_push        = 1'b1;
                        o_desc.status = ST_LEN;
                        o_desc.length = i_byte;
                        o_desc.ftype  = 8'd0;
                        o_desc.plen   = '0;
                    end else begin
                        n_pos = 7'd2;
                    end
                end else if (r_pos == 7'd2) begin
                    n_type = i_byte;
                    n_crc  = crc8_step(8'd0, i_byte, i_poly);
                    n_pos  = 7'd3;
                end else if ({2'b00, r_pos} < ({1'b0, r_len} + 9'd1)) begin
                    o_we  = 1'b1;
                    n_crc = crc8_step(r_crc, i_byte, i_poly);
                    n_pos = r_pos + 7'd1;
                end else begin
                    // CRC byte closes the frame
                    n_cap  = 1'b0;
                    n_pos  = 7'd0;
                    o_push = 1'b1;
                    if (r_crc != i_byte) begin
                        o_desc.status = ST_CRC;
                        o_desc.plen   = '0;
                    end else begin
                        set_busy = (plen != '0);
                    end
                end
            end
        end
    end

    // bank ownership: set when a good frame with payload is queued, cleared on release
    always_comb begin
        n_busy  = r_busy;
        n_wbank = r_wbank;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[r_wbank] = 1'b1;
            n_wbank         = ~r_wbank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 1'b0;
            r_pos   <= 7'd0;
            r_sync  <= 8'd0;
            r_len   <= 8'd0;
            r_type  <= 8'd0;
            r_crc   <= 8'd0;
            r_busy  <= 2'b00;
            r_wbank <= 1'b0;
        end else begin
            r_cap   <= n_cap;
            r_pos   <= n_pos;
            r_sync  <= n_sync;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_busy  <= n_busy;
            r_wbank <= n_wbank;
        end
    end

endmodule

>>> hw/rtl/crcdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_queue - two-entry descriptor queue
// Decouples frame capture from result generation.
// ----------------------------------------------------------------------------
module crcdf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crcdf_pkg::t_desc i_desc,
    output logic             o_full,
    input  logic             i_pop,
    output crcdf_pkg::t_desc o_desc,
    output logic             o_empty
);
    import crcdf_pkg::*;

    t_desc      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_desc  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

>>> hw/rtl/crcdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcdf_back - result generator
// Takes descriptors off the queue, reads the payload bank one byte a cycle
// when not stalled; results pass a read stage and an output register.
// ----------------------------------------------------------------------------
module crcdf_back #(
    parameter int MAX_PAYLOAD = crcdf_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(2 * MAX_PAYLOAD)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crcdf_pkg::t_desc    i_desc,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    input  logic [7:0]          i_rdata,
    output crcdf_pkg::t_release o_release,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [39:0]         o_data,
    output logic [2:0]          o_user,
    output logic                o_last
);
    import crcdf_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       sync;
        logic [7:0]       length;
        logic [7:0]       ftype;
        logic             has;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_item;

    t_desc            r_cur;
    logic             r_active, n_active;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_s1_v, n_s1_v;
    t_item            r_s1, n_s1;
    logic             r_ov;
    t_item            r_out;
    logic [7:0]       r_pbyte;

    logic out_load;
    logic adv_ok;
    logic has_pl;
    logic idx_last;

    assign out_load = r_s1_v && (!r_ov || i_ready);
    assign adv_ok   = !r_s1_v || out_load;
    assign has_pl   = (r_cur.status == ST_GOOD) && (r_cur.plen != '0);
    assign idx_last = (r_idx == r_cur.plen - IDX_W'(1));
    assign o_pop    = !r_active && !i_empty;
    assign o_raddr  = AW'(r_idx) + (r_cur.bank ? AW'(MAX_PAYLOAD) : AW'(0));

    // issue one result per cycle from the current descriptor while the read stage can advance
    always_comb begin
        n_active  = r_active;
        n_idx     = r_idx;
        n_s1_v    = out_load ? 1'b0 : r_s1_v;
        n_s1      = r_s1;
        o_re      = 1'b0;
        o_release = '{valid: 1'b0, bank: r_cur.bank};
        if (o_pop) begin
            n_active = 1'b1;
            n_idx    = '0;
        end else if (r_active && adv_ok) begin
            n_s1_v = 1'b1;
            n_s1   = '{status: r_cur.status, sync: r_cur.sync, length: r_cur.length,
                       ftype: r_cur.ftype, has: has_pl, idx: has_pl ? r_idx : '0,
                       last: !has_pl || idx_last};
            if (has_pl) begin
                o_re  = 1'b1;
                n_idx = r_idx + IDX_W'(1);
                if (idx_last) begin
                    n_active        = 1'b0;
                    o_release.valid = 1'b1;
                end
            end else begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_s1_v   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_active <= n_active;
            r_s1_v   <= n_s1_v;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        r_idx <= n_idx;
        r_s1  <= n_s1;
        if (out_load) begin
            r_out   <= r_s1;
            r_pbyte <= r_s1.has ? i_rdata : 8'd0;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = {2'b00, r_out.idx, r_pbyte, r_out.ftype, r_out.length, r_out.sync};
    assign o_user  = {r_out.has, r_out.status};
    assign o_last  = r_out.last;

endmodule

>>> hw/rtl/crc_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer - CRC-8 checked serial frame deframer
// Captures sync/length/type/payload/CRC frames from a byte stream and emits
// the payload of good frames or one status item per bad frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one received byte per item in tdata, tuser[0] flags the
//   first byte after an idle line (restarts capture, taken as sync byte).
//   Master stream: one result per item; a good frame gives one item per
//   payload byte with tlast on the final one; a CRC mismatch, a bad length
//   or an empty good frame gives a single item with tlast set.
//   APB port: register 0 (byte address 0) is the CRC-8 polynomial.
//   Throughput: one byte per cycle in while tready is high; results one per
//   cycle within a run while the master stream accepts them, from a two-bank
//   RAM with registered read. With the back end idle, a frame's first result
//   follows its last byte via descriptor fetch, RAM read and output reg.
//   Capture stalls (tready low) only while the two-entry descriptor queue
//   is full or the bank it would fill is still being read out, which
//   happens when the receiver holds off the master stream for long.
//   Reset empties the queue, drops any partial frame and restores the
//   polynomial to 0xD5.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer #(
    parameter int MAX_PAYLOAD = crcdf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] frame_start
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] sync_value, [15:8] length_value,
                                     // [23:16] frame_type, [31:24] payload_byte,
                                     // [37:32] payload_index, [39:38] zero
    output logic [2:0]  o_m_tuser,   // [1:0] status, [2] has_payload
    output logic        o_m_tlast,   // last
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import crcdf_pkg::*;

    localparam int DEPTH = 2 * MAX_PAYLOAD;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] r_poly;
    logic       cfg_wr;

    logic          q_push, q_full, q_pop, q_empty;
    t_desc         q_din, q_dout;
    t_release      release_bank;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // configuration register
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = (i_paddr[2] == 1'b0) ? {24'd0, r_poly} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= CRC_POLY_RST;
        end else if (cfg_wr && i_paddr[2] == 1'b0) begin
            r_poly <= i_pwdata[7:0];
        end
    end

    crcdf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_start   (i_s_tuser[0]),
        .i_poly    (r_poly),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_desc    (q_din),
        .i_release (release_bank),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata)
    );

    crcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_desc  (q_dout),
        .o_empty (q_empty)
    );

    crcdf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    crcdf_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_desc    (q_dout),
        .i_empty   (q_empty),
        .o_pop     (q_pop),
        .o_re      (ram_re),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata),
        .o_release (release_bank),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_user    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

    // a descriptor is never offered to a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("descriptor pushed into full queue");

    // payload items only belong to good frames
    a_payload_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == ST_GOOD))
        else $error("payload item with error status");

    // error and empty-frame items close their run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[2]) |-> o_m_tlast)
        else $error("status item without tlast");

endmodule
